### hdl/lfsf_pkg.sv
`default_nettype none

package lfsf_pkg;

	// Grid geometry and field widths
	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int SCORE_W   = 11;
	localparam int POS_W     = 10;
	localparam int BYTE_W    = 8;
	localparam int CFG_W     = 11;

	// Register reset values
	localparam logic [BYTE_W-1:0]  OBSTACLE_RESET = BYTE_W'(111);
	localparam logic [SCORE_W-1:0] WIDTH_RESET    = SCORE_W'(MAX_WIDTH);

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_OBSTACLE = 1'b0,
		CFG_WIDTH    = 1'b1
	} cfg_index_t;

	// One accepted cell together with its grid position
	typedef struct packed {
		logic [BYTE_W-1:0] cell_byte;
		logic              last_cell;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
	} cell_t;

	// Line buffer write port
	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [SCORE_W-1:0] data;
	} lb_wr_t;

	// Best square seen so far
	typedef struct packed {
		logic [SCORE_W-1:0] side;
		logic [POS_W-1:0]   row;
		logic [POS_W-1:0]   col;
	} best_t;

endpackage

`default_nettype wire

### hdl/lfsf_cell_if.sv
`default_nettype none

interface lfsf_cell_if;
	logic                           valid;
	logic                           ready;
	logic [lfsf_pkg::BYTE_W-1:0]    cell_byte;
	logic                           last_cell;

	modport source (output valid, output cell_byte, output last_cell, input ready);
	modport sink   (input valid, input cell_byte, input last_cell, output ready);
endinterface

`default_nettype wire

### hdl/lfsf_result_if.sv
`default_nettype none

interface lfsf_result_if;
	logic                           valid;
	logic                           ready;
	logic [lfsf_pkg::SCORE_W-1:0]   best_side;
	logic [lfsf_pkg::POS_W-1:0]     corner_row;
	logic [lfsf_pkg::POS_W-1:0]     corner_col;

	modport source (output valid, output best_side, output corner_row, output corner_col,
		input ready);
	modport sink   (input valid, input best_side, input corner_row, input corner_col,
		output ready);
endinterface

`default_nettype wire

### hdl/largest_free_square_finder.sv
// Largest free square finder.
// Cells of a character grid arrive on the cells channel in row-major order, one
// word per cell; a cell equal to the obstacle byte is blocked. The word with
// last_cell set closes the grid, and one result word follows on the result
// channel: the side of the largest free square (0 if none) and the row and
// column of its bottom-right cell. Rows wrap at the grid_width register.
// Configuration goes through cfg_write/cfg_index/cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Throughput: one cell per cycle, set by the single read and single write port of the
// previous-row score buffer and the score recurrence, while no last cell is stalled.
// Latency: a cell is scored in the cycle after it is accepted, but a last cell waits
// for result room; the result is valid from the cycle after the last cell is scored.
// A waiting result does not stop the stream: cells keep flowing until the next
// last cell reaches the scoring stage while the result is still untaken.
// Reset clears counters, tracking and the registers to their defaults; the
// score buffer needs no clearing, as every entry used is written one row earlier.
`default_nettype none

module largest_free_square_finder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	lfsf_cell_if.sink                            cells,
	lfsf_result_if.source                        result,
	input  wire logic                            cfg_write,
	input  wire logic [0:0]                      cfg_index,
	input  wire logic [lfsf_pkg::CFG_W-1:0]      cfg_data
);

	logic [lfsf_pkg::BYTE_W-1:0]  obstacle_q;
	logic [lfsf_pkg::SCORE_W-1:0] width_q;
	logic [lfsf_pkg::SCORE_W-1:0] act_width;
	logic [lfsf_pkg::POS_W-1:0]   row_q;
	logic [lfsf_pkg::POS_W-1:0]   col_q;
	logic                         in_accept;
	logic                         s1_valid_s1;
	lfsf_pkg::cell_t              cell_s1;
	logic                         s1_fire;
	logic                         out_free;
	logic                         out_valid_q;
	lfsf_pkg::best_t              res_q;
	lfsf_pkg::best_t              best_next;
	lfsf_pkg::lb_wr_t             lb_wr;
	logic [lfsf_pkg::SCORE_W-1:0] above;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle_q <= lfsf_pkg::OBSTACLE_RESET;
			width_q    <= lfsf_pkg::WIDTH_RESET;
		end else if (cfg_write) begin
			case (lfsf_pkg::cfg_index_t'(cfg_index))
				lfsf_pkg::CFG_OBSTACLE: obstacle_q <= cfg_data[lfsf_pkg::BYTE_W-1:0];
				lfsf_pkg::CFG_WIDTH:    width_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective row width, clamped to 1..MAX_WIDTH
	always_comb begin
		if (width_q == '0) begin
			act_width = lfsf_pkg::SCORE_W'(1);
		end else if (width_q > lfsf_pkg::SCORE_W'(lfsf_pkg::MAX_WIDTH)) begin
			act_width = lfsf_pkg::SCORE_W'(lfsf_pkg::MAX_WIDTH);
		end else begin
			act_width = width_q;
		end
	end

	// Handshake: the scoring stage stalls only on a last cell with no room for the result
	assign out_free    = !out_valid_q || result.ready;
	assign s1_fire     = s1_valid_s1 && (!cell_s1.last_cell || out_free);
	assign cells.ready = !s1_valid_s1 || s1_fire;
	assign in_accept   = cells.valid && cells.ready;

	// Grid position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_accept) begin
			if (cells.last_cell) begin
				row_q <= '0;
				col_q <= '0;
			end else if (({1'b0, col_q} + lfsf_pkg::SCORE_W'(1)) >= act_width) begin
				row_q <= row_q + lfsf_pkg::POS_W'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + lfsf_pkg::POS_W'(1);
			end
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (cells.ready) begin
			s1_valid_s1 <= cells.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cell_s1.cell_byte <= cells.cell_byte;
			cell_s1.last_cell <= cells.last_cell;
			cell_s1.row       <= row_q;
			cell_s1.col       <= col_q;
		end
	end

	// Previous-row scores, read as the cell is accepted
	lfsf_line_buffer u_line_buffer (
		.clk     (clk),
		.rd_en   (in_accept),
		.rd_addr (col_q[lfsf_pkg::ADDR_W-1:0]),
		.wr      (lb_wr),
		.rd_data (above)
	);

	lfsf_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (s1_fire),
		.cur       (cell_s1),
		.above     (above),
		.obstacle  (obstacle_q),
		.wr        (lb_wr),
		.best_next (best_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && cell_s1.last_cell) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && cell_s1.last_cell) begin
			res_q <= best_next;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.best_side  = res_q.side;
	assign result.corner_row = res_q.row;
	assign result.corner_col = res_q.col;

endmodule

`default_nettype wire

### hdl/lfsf_line_buffer.sv
`default_nettype none

// Previous-row score memory: one write and one registered read per cycle.
// A read that hits the address being written in the same cycle returns the new data.
module lfsf_line_buffer (
	input  wire logic                           clk,
	input  wire logic                           rd_en,
	input  wire logic [lfsf_pkg::ADDR_W-1:0]    rd_addr,
	input  wire lfsf_pkg::lb_wr_t               wr,
	output logic      [lfsf_pkg::SCORE_W-1:0]   rd_data
);

	logic [lfsf_pkg::SCORE_W-1:0] mem [lfsf_pkg::MAX_WIDTH];
	logic [lfsf_pkg::SCORE_W-1:0] rd_q;
	logic [lfsf_pkg::SCORE_W-1:0] byp_data_q;
	logic                         byp_q;

	// Memory array with registered read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_q      <= wr.en && (wr.addr == rd_addr);
			byp_data_q <= wr.data;
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

### hdl/lfsf_tracker.sv
`default_nettype none

// Scores the cell held in the input stage and keeps the running best square.
module lfsf_tracker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           fire,
	input  wire lfsf_pkg::cell_t                cur,
	input  wire logic [lfsf_pkg::SCORE_W-1:0]   above,
	input  wire logic [lfsf_pkg::BYTE_W-1:0]    obstacle,
	output lfsf_pkg::lb_wr_t                    wr,
	output lfsf_pkg::best_t                     best_next
);

	logic [lfsf_pkg::SCORE_W-1:0] left_q;
	logic [lfsf_pkg::SCORE_W-1:0] diag_q;
	lfsf_pkg::best_t              best_q;
	logic [lfsf_pkg::SCORE_W-1:0] min3;
	logic [lfsf_pkg::SCORE_W-1:0] score;

	// Three-way minimum and cell score
	always_comb begin
		min3 = above;
		if (left_q < min3) begin
			min3 = left_q;
		end
		if (diag_q < min3) begin
			min3 = diag_q;
		end
		if (cur.cell_byte == obstacle) begin
			score = '0;
		end else if ((cur.row == '0) || (cur.col == '0)) begin
			score = lfsf_pkg::SCORE_W'(1);
		end else begin
			score = min3 + lfsf_pkg::SCORE_W'(1);
		end
	end

	// Best update; ties go to the smaller top row, then the smaller left column
	always_comb begin
		best_next = best_q;
		if (score > best_q.side) begin
			best_next.side = score;
			best_next.row  = cur.row;
			best_next.col  = cur.col;
		end else if ((score == best_q.side) &&
				((cur.row < best_q.row) ||
				((cur.row == best_q.row) && (cur.col < best_q.col)))) begin
			best_next.row = cur.row;
			best_next.col = cur.col;
		end
	end

	assign wr.en   = fire;
	assign wr.addr = cur.col[lfsf_pkg::ADDR_W-1:0];
	assign wr.data = score;

	// Neighbor scores and best square; cleared after the last cell of a grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			diag_q <= '0;
			best_q <= '0;
		end else if (fire) begin
			if (cur.last_cell) begin
				left_q <= '0;
				diag_q <= '0;
				best_q <= '0;
			end else begin
				left_q <= score;
				diag_q <= above;
				best_q <= best_next;
			end
		end
	end

endmodule

`default_nettype wire
